// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

    // Screen geometry
    localparam int ROWS     = 25;
    localparam int COLS     = 80;
    localparam int TAB_STOP = 4;
    localparam int CELLS    = ROWS * COLS;
    localparam int LAST_ROW = ROWS - 1;
    // Cells moved up by one scroll; the bottom row is blank-filled after them
    localparam int COPY_CELLS = (ROWS - 1) * COLS;

    // Internal cursor and address widths
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int COLX_W = COL_W + 1;
    localparam int ADDR_W = $clog2(CELLS);

    // Transaction field widths
    localparam int KIND_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int INDEX_W     = 11;
    localparam int CELL_W      = 16;
    localparam int ATTR_W      = 8;

    // Configuration port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = '0;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRINT = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_MOVE  = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MEM_IDLE    = 2'd0,
        MEM_COPY_RD = 2'd1,
        MEM_COPY_WR = 2'd2,
        MEM_FILL    = 2'd3
    } mem_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        logic    exec;
        mem_op_t mem_op;
        logic    init_fill;
        logic    addr_clr;
        logic    load_result;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  print_scroll;
        logic  fill_last;
        logic  copy_last;
    } stat_t;

endpackage

// ----- rtl/core/tcw_item_if.sv -----
interface tcw_item_if;
    import tcw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] target_row;
    logic [COL_FIELD_W-1:0] target_col;
    logic [INDEX_W-1:0]     read_index;

    modport source (
        output valid, kind, char_code, target_row, target_col, read_index,
        input  ready
    );

    modport sink (
        input  valid, kind, char_code, target_row, target_col, read_index,
        output ready
    );

endinterface

// ----- rtl/core/tcw_result_if.sv -----
interface tcw_result_if;
    import tcw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_col;
    logic [INDEX_W-1:0]     cursor_offset;
    logic                   cursor_written;
    logic                   did_scroll;
    logic [CELL_W-1:0]      cell_value;

    modport source (
        output valid, cursor_row, cursor_col, cursor_offset, cursor_written,
               did_scroll, cell_value,
        input  ready
    );

    modport sink (
        input  valid, cursor_row, cursor_col, cursor_offset, cursor_written,
               did_scroll, cell_value,
        output ready
    );

endinterface

// ----- rtl/core/tcw_ctrl.sv -----
module tcw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    output logic           result_valid,
    input  logic           result_ready,
    output tcw_pkg::cmd_t  cmd,
    input  tcw_pkg::stat_t stat
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_COPY_RD,
        S_COPY_WR,
        S_FILL,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    // Sequence the work of one transaction
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.mem_op    = MEM_FILL;
                cmd.init_fill = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec     = 1'b1;
                cmd.addr_clr = 1'b1;
                if (stat.kind == KIND_CLEAR)
                begin
                    state_next = S_FILL;
                end
                else if (stat.kind == KIND_PRINT && stat.print_scroll)
                begin
                    state_next = S_COPY_RD;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_COPY_RD:
            begin
                cmd.mem_op = MEM_COPY_RD;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.mem_op = MEM_COPY_WR;
                state_next = stat.copy_last ? S_FILL : S_COPY_RD;
            end
            S_FILL:
            begin
                cmd.mem_op = MEM_FILL;
                if (stat.fill_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // Wait for the output register to free up
                if (!result_valid_reg || result_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold a finished result until the receiver takes it
    always_comb
    begin
        if (cmd.load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

// ----- rtl/core/tcw_datapath.sv -----
module tcw_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcw_pkg::cmd_t                   cmd,
    output tcw_pkg::stat_t                  stat,
    input  logic [tcw_pkg::ATTR_W-1:0]      attr,
    input  logic [tcw_pkg::KIND_W-1:0]      kind,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcw_pkg::ROW_FIELD_W-1:0] target_row,
    input  logic [tcw_pkg::COL_FIELD_W-1:0] target_col,
    input  logic [tcw_pkg::INDEX_W-1:0]     read_index,
    output logic [tcw_pkg::ROW_FIELD_W-1:0] cursor_row,
    output logic [tcw_pkg::COL_FIELD_W-1:0] cursor_col,
    output logic [tcw_pkg::INDEX_W-1:0]     cursor_offset,
    output logic                            cursor_written,
    output logic                            did_scroll,
    output logic [tcw_pkg::CELL_W-1:0]      cell_value
);
    import tcw_pkg::*;

    // Captured transaction
    kind_t                  kind_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic [ROW_FIELD_W-1:0] trow_reg;
    logic [COL_FIELD_W-1:0] tcol_reg;
    logic [INDEX_W-1:0]     ridx_reg;

    // Cursor and per-transaction flags
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             written_reg;
    logic             scroll_reg;

    // Screen store
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    // Result register
    logic [ROW_FIELD_W-1:0] res_row_reg;
    logic [COL_FIELD_W-1:0] res_col_reg;
    logic [INDEX_W-1:0]     res_offset_reg;
    logic                   res_written_reg;
    logic                   res_scroll_reg;
    logic [CELL_W-1:0]      res_cell_reg;

    logic [COLX_W-1:0] col_ext;
    logic [COLX_W-1:0] col_x;
    logic              printable;
    logic              line_feed;
    logic              wrap;
    logic              row_step;
    logic              print_scroll;
    logic [ROW_W-1:0]  prn_row;
    logic [COL_W-1:0]  prn_col;
    logic [ADDR_W-1:0] cur_offset;
    logic              move_ok;
    logic              ridx_ok;

    // Capture the transaction fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            char_reg <= char_code;
            trow_reg <= target_row;
            tcol_reg <= target_col;
            ridx_reg <= read_index;
        end
    end

    assign col_ext    = COLX_W'(col_reg);
    assign cur_offset = ADDR_W'(row_reg) * ADDR_W'(COLS) + ADDR_W'(col_reg);
    assign move_ok    = (trow_reg < ROW_FIELD_W'(ROWS)) && (tcol_reg < COL_FIELD_W'(COLS));
    assign ridx_ok    = (ridx_reg < INDEX_W'(CELLS));

    // Work out the cursor after a printed byte
    always_comb
    begin
        col_x     = col_ext;
        printable = 1'b0;
        line_feed = 1'b0;
        case (char_reg)
            CHAR_BS:
            begin
                if (col_reg != '0)
                begin
                    col_x = col_ext - COLX_W'(1);
                end
            end
            CHAR_TAB:
            begin
                col_x = COLX_W'(col_ext - col_ext % TAB_STOP + TAB_STOP);
            end
            CHAR_CR:
            begin
                col_x = '0;
            end
            CHAR_LF:
            begin
                col_x     = '0;
                line_feed = 1'b1;
            end
            default:
            begin
                // Printable bytes only; other controls and high bytes leave the cursor
                if (char_reg >= CHAR_BLANK && char_reg <= CHAR_DEL)
                begin
                    printable = 1'b1;
                    col_x     = col_ext + COLX_W'(1);
                end
            end
        endcase
        wrap         = (col_x >= COLX_W'(COLS));
        row_step     = line_feed || wrap;
        print_scroll = row_step && (row_reg == ROW_W'(LAST_ROW));
        prn_col      = wrap ? '0 : COL_W'(col_x);
        prn_row      = (row_step && !print_scroll) ? row_reg + ROW_W'(1) : row_reg;
    end

    // Update the cursor and the flags of the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            written_reg <= 1'b0;
            scroll_reg  <= 1'b0;
        end
        else if (cmd.exec)
        begin
            case (kind_reg)
                KIND_PRINT:
                begin
                    row_reg     <= prn_row;
                    col_reg     <= prn_col;
                    written_reg <= 1'b1;
                    scroll_reg  <= print_scroll;
                end
                KIND_CLEAR:
                begin
                    row_reg     <= '0;
                    col_reg     <= '0;
                    written_reg <= 1'b1;
                    scroll_reg  <= 1'b0;
                end
                KIND_MOVE:
                begin
                    if (move_ok)
                    begin
                        row_reg <= ROW_W'(trow_reg);
                        col_reg <= COL_W'(tcol_reg);
                    end
                    written_reg <= move_ok;
                    scroll_reg  <= 1'b0;
                end
                default:
                begin
                    written_reg <= 1'b0;
                    scroll_reg  <= 1'b0;
                end
            endcase
        end
    end

    // Advance the sweep address for fills and copies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.addr_clr)
        begin
            addr_reg <= '0;
        end
        else if (cmd.mem_op == MEM_FILL || cmd.mem_op == MEM_COPY_WR)
        begin
            addr_reg <= addr_reg + ADDR_W'(1);
        end
    end

    // Select the store write
    always_comb
    begin
        case (cmd.mem_op)
            MEM_FILL:
            begin
                mem_we = 1'b1;
                mem_wa = addr_reg;
                mem_wd = cmd.init_fill ? RESET_CELL : {attr, CHAR_BLANK};
            end
            MEM_COPY_WR:
            begin
                mem_we = 1'b1;
                mem_wa = addr_reg;
                mem_wd = rd_data_reg;
            end
            default:
            begin
                mem_we = cmd.exec && (kind_reg == KIND_PRINT) && printable;
                mem_wa = cur_offset;
                mem_wd = {attr, char_reg};
            end
        endcase
    end

    // Read one row below while scrolling, else the requested cell
    assign mem_ra = (cmd.mem_op == MEM_COPY_RD) ? addr_reg + ADDR_W'(COLS)
                  : (ridx_ok ? ADDR_W'(ridx_reg) : '0);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            res_row_reg     <= ROW_FIELD_W'(row_reg);
            res_col_reg     <= COL_FIELD_W'(col_reg);
            res_offset_reg  <= INDEX_W'(cur_offset);
            res_written_reg <= written_reg;
            res_scroll_reg  <= scroll_reg;
            res_cell_reg    <= (kind_reg == KIND_READ && ridx_ok) ? rd_data_reg : '0;
        end
    end

    assign stat.kind         = kind_reg;
    assign stat.print_scroll = print_scroll;
    assign stat.fill_last    = (addr_reg == ADDR_W'(CELLS - 1));
    assign stat.copy_last    = (addr_reg == ADDR_W'(COPY_CELLS - 1));

    assign cursor_row     = res_row_reg;
    assign cursor_col     = res_col_reg;
    assign cursor_offset  = res_offset_reg;
    assign cursor_written = res_written_reg;
    assign did_scroll     = res_scroll_reg;
    assign cell_value     = res_cell_reg;

endmodule

// ----- rtl/core/text_console_writer_top.sv -----
// Text console writer: an 80x25 screen of 16-bit cells (attribute high, char low).
// Channel item takes one transaction per command: print a byte, clear the screen,
// move the cursor or read a cell. Channel result returns exactly one transaction
// per item, in order, with the cursor after the item and the cell read.
// The APB port holds the text attribute at address 0 (reset 0x07).
// Sequence: an item is taken in the idle state, worked on in the execute state,
// and its result is loaded in the result state once the output register is
// free; the next item is taken only after that load.
// Clear walks the store one cell a cycle through all 2000 cells.
// A scroll moves each cell with a read state and a write state, then blanks the
// bottom row.
// Reset: the cursor goes home and a clearing pass writes blank cells (0x0720)
// through the whole store while item.ready stays low; configuration writes
// are taken throughout.
// Receiver stall: a finished result waits in the output register; the next item
// is still taken and worked, then held until the output register frees.
module text_console_writer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    tcw_item_if.sink                           item,
    tcw_result_if.source                       result
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic              attr_we;
    cmd_t              cmd;
    stat_t             stat;

    // Decode the attribute register write
    assign attr_we = psel && penable && pwrite && (paddr == ATTR_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (attr_we)
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    assign prdata = (paddr == ATTR_ADDR) ? APB_DATA_W'(attr_reg) : '0;
    assign pready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    tcw_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .attr           (attr_reg),
        .kind           (item.kind),
        .char_code      (item.char_code),
        .target_row     (item.target_row),
        .target_col     (item.target_col),
        .read_index     (item.read_index),
        .cursor_row     (result.cursor_row),
        .cursor_col     (result.cursor_col),
        .cursor_offset  (result.cursor_offset),
        .cursor_written (result.cursor_written),
        .did_scroll     (result.did_scroll),
        .cell_value     (result.cell_value)
    );

`ifndef SYNTHESIS
    // Take one item at a time
    ap_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("item taken while the previous one is in work");

    // Keep the reported cursor on the screen
    ap_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.cursor_row < ROWS) && (result.cursor_col < COLS))
        else $error("cursor off screen");

    // Match the linear offset to the row and column
    ap_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.cursor_offset ==
            INDEX_W'(result.cursor_row * COLS + result.cursor_col))
        else $error("cursor offset does not match row and column");

    // Leave the cursor on the last row after a scroll
    ap_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.did_scroll |->
            (result.cursor_row == ROW_FIELD_W'(LAST_ROW)) && result.cursor_written)
        else $error("scroll without cursor on last row");
`endif

endmodule

// ----- bench/text_console_writer_top_tb.sv -----
module text_console_writer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int    SETTLE_CYCLES = 16;
    localparam int    PHASE_ITEMS   = 200;
    localparam int    MAX_INDEX     = (1 << INDEX_W) - 1;
    // Worst case: every command scrolls and meets the longest gap and stall
    localparam longint RUN_LIMIT    = 64'd2000 + 64'd1100 * 64'd4200 * 64'd3;

    typedef struct {
        kind_t                  kind;
        logic [CHAR_W-1:0]      char_code;
        logic [ROW_FIELD_W-1:0] target_row;
        logic [COL_FIELD_W-1:0] target_col;
        logic [INDEX_W-1:0]     read_index;
    } console_cmd_t;

    typedef struct {
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
        logic [INDEX_W-1:0]     cursor_offset;
        logic                   cursor_written;
        logic                   did_scroll;
        logic [CELL_W-1:0]      cell_value;
    } console_view_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    tcw_item_if   item_bus ();
    tcw_result_if result_bus ();

    text_console_writer_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_bus),
        .result  (result_bus)
    );

    // Shadow of the screen, cursor and attribute
    logic [CELL_W-1:0] screen_shadow [CELLS];
    int                shadow_row;
    int                shadow_col;
    logic [ATTR_W-1:0] shadow_attr;

    console_cmd_t  cmd_backlog [$];
    console_view_t awaited_views [$];
    console_cmd_t  in_flight;
    console_view_t want;

    int     errors;
    int     queued_total;
    int     commands_sent;
    int     results_checked;
    int     scroll_count;
    int     attr_settings;
    int     kind_count [4];
    int     calm_left [2];
    int     src_gap;
    int     sink_stall;
    logic   result_fired;
    longint cycle_count;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int pick_idle(int side);
        int roll;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the shadow console by one command and return its result
    function automatic console_view_t apply_to_screen(console_cmd_t cmd);
        console_view_t view;
        logic [CELL_W-1:0] blank;
        int i;
        view = '{default: '0};
        blank = {shadow_attr, CHAR_BLANK};
        kind_count[cmd.kind]++;
        case (cmd.kind)
            KIND_PRINT:
            begin
                case (cmd.char_code)
                    CHAR_BS:
                        if (shadow_col > 0)
                            shadow_col--;
                    CHAR_TAB:
                        shadow_col = shadow_col + TAB_STOP - (shadow_col % TAB_STOP);
                    CHAR_CR:
                        shadow_col = 0;
                    CHAR_LF:
                    begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                    default:
                        if (cmd.char_code >= CHAR_BLANK && cmd.char_code <= CHAR_DEL)
                        begin
                            screen_shadow[shadow_row * COLS + shadow_col] =
                                {shadow_attr, cmd.char_code};
                            shadow_col++;
                        end
                endcase
                // wrap at end of line
                if (shadow_col >= COLS)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // scroll up one line past the bottom row
                if (shadow_row >= ROWS)
                begin
                    for (i = 0; i < COPY_CELLS; i++)
                        screen_shadow[i] = screen_shadow[i + COLS];
                    for (i = COPY_CELLS; i < CELLS; i++)
                        screen_shadow[i] = blank;
                    shadow_row = LAST_ROW;
                    view.did_scroll = 1'b1;
                    scroll_count++;
                end
                view.cursor_written = 1'b1;
            end
            KIND_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_shadow[i] = blank;
                shadow_row = 0;
                shadow_col = 0;
                view.cursor_written = 1'b1;
            end
            KIND_MOVE:
                if (cmd.target_row < ROWS && cmd.target_col < COLS)
                begin
                    shadow_row = cmd.target_row;
                    shadow_col = cmd.target_col;
                    view.cursor_written = 1'b1;
                end
            default:
                if (cmd.read_index < CELLS)
                    view.cell_value = screen_shadow[cmd.read_index];
        endcase
        view.cursor_row    = ROW_FIELD_W'(shadow_row);
        view.cursor_col    = COL_FIELD_W'(shadow_col);
        view.cursor_offset = INDEX_W'(shadow_row * COLS + shadow_col);
        return view;
    endfunction

    function automatic void check_field(string name, int unsigned expected,
                                        int unsigned actual);
        if (expected != actual)
        begin
            $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h",
                     $time, name, expected, actual);
            errors++;
        end
    endfunction

    // Command builders; fields a kind does not use stay random
    function automatic console_cmd_t random_fields();
        console_cmd_t c;
        c.kind       = kind_t'($urandom_range(3));
        c.char_code  = CHAR_W'($urandom_range(255));
        c.target_row = ROW_FIELD_W'($urandom_range(31));
        c.target_col = COL_FIELD_W'($urandom_range(127));
        c.read_index = INDEX_W'($urandom_range(MAX_INDEX));
        return c;
    endfunction

    function automatic void push_raw(console_cmd_t c);
        cmd_backlog.push_back(c);
        queued_total++;
    endfunction

    function automatic void push_print(logic [CHAR_W-1:0] ch);
        console_cmd_t c;
        c = random_fields();
        c.kind = KIND_PRINT;
        c.char_code = ch;
        push_raw(c);
    endfunction

    function automatic void push_clear();
        console_cmd_t c;
        c = random_fields();
        c.kind = KIND_CLEAR;
        push_raw(c);
    endfunction

    function automatic void push_move(int row, int col);
        console_cmd_t c;
        c = random_fields();
        c.kind = KIND_MOVE;
        c.target_row = ROW_FIELD_W'(row);
        c.target_col = COL_FIELD_W'(col);
        push_raw(c);
    endfunction

    function automatic void push_read(int index);
        console_cmd_t c;
        c = random_fields();
        c.kind = KIND_READ;
        c.read_index = INDEX_W'(index);
        push_raw(c);
    endfunction

    // Mostly printable text with an occasional cursor control
    function automatic logic [CHAR_W-1:0] text_byte();
        if ($urandom_range(11) != 0)
            return CHAR_W'($urandom_range(CHAR_BLANK, CHAR_DEL));
        case ($urandom_range(3))
            0: return CHAR_BS;
            1: return CHAR_TAB;
            2: return CHAR_CR;
            default: return CHAR_LF;
        endcase
    endfunction

    function automatic int random_index();
        if ($urandom_range(9) == 0)
            return $urandom_range(CELLS, MAX_INDEX);
        return $urandom_range(CELLS - 1);
    endfunction

    // Queue random command sequences until count more are waiting
    function automatic void fill_random(int count);
        int goal;
        int roll;
        int n;
        goal = queued_total + count;
        while (queued_total < goal)
        begin
            roll = $urandom_range(99);
            n = $urandom_range(1, 4);
            if (roll < 35)
            begin
                repeat ($urandom_range(3, 12)) push_print(text_byte());
            end
            else if (roll < 55)
            begin
                push_move($urandom_range(LAST_ROW), $urandom_range(COLS - 1));
                repeat ($urandom_range(1, 6)) push_print(text_byte());
            end
            else if (roll < 60)
            begin
                // run off the end of the bottom row
                push_move(LAST_ROW, $urandom_range(COLS - 8, COLS - 1));
                repeat ($urandom_range(2, 10)) push_print(text_byte());
                push_read(LAST_ROW * COLS - 1 - $urandom_range(7));
            end
            else if (roll < 65)
            begin
                // line feeds near the bottom
                push_move($urandom_range(LAST_ROW - 1, LAST_ROW), $urandom_range(COLS - 1));
                push_print(CHAR_LF);
                push_print(CHAR_LF);
                push_read(LAST_ROW * COLS + $urandom_range(COLS - 1));
            end
            else if (roll < 80)
            begin
                repeat (n) push_read(random_index());
            end
            else if (roll < 88)
            begin
                repeat (n) push_raw(random_fields());
            end
            else if (roll < 94)
            begin
                // high bytes and unused control bytes
                repeat (n)
                    push_print($urandom_range(1) ? CHAR_W'($urandom_range(8'h80, 8'hFF))
                                                 : CHAR_W'($urandom_range(8'h00, 8'h1F)));
            end
            else if (roll < 96)
            begin
                push_clear();
                repeat (n) push_read(random_index());
            end
            else
            begin
                // targets off the screen
                if ($urandom_range(1))
                    push_move($urandom_range(ROWS, 31), $urandom_range(127));
                else
                    push_move($urandom_range(31), $urandom_range(COLS, 127));
            end
        end
    endfunction

    // Write the attribute register, then read it back
    task automatic program_attribute(input logic [ATTR_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ATTR_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_attr = value;
        attr_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("text_attribute readback", APB_DATA_W'(value), readback);
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || item_bus.valid || awaited_views.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                awaited_views.push_back(apply_to_screen(in_flight));
                commands_sent++;
            end
            if (!item_bus.valid || item_bus.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    item_bus.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    in_flight = cmd_backlog.pop_front();
                    item_bus.valid      <= 1'b1;
                    item_bus.kind       <= in_flight.kind;
                    item_bus.char_code  <= in_flight.char_code;
                    item_bus.target_row <= in_flight.target_row;
                    item_bus.target_col <= in_flight.target_col;
                    item_bus.read_index <= in_flight.read_index;
                    src_gap = pick_idle(0);
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_fired = result_bus.valid && result_bus.ready;
            if (result_fired)
            begin
                if (awaited_views.size() == 0)
                begin
                    $display("%0t result transaction with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = awaited_views.pop_front();
                    check_field("cursor_row", want.cursor_row, result_bus.cursor_row);
                    check_field("cursor_col", want.cursor_col, result_bus.cursor_col);
                    check_field("cursor_offset", want.cursor_offset,
                                result_bus.cursor_offset);
                    check_field("cursor_written", want.cursor_written,
                                result_bus.cursor_written);
                    check_field("did_scroll", want.did_scroll, result_bus.did_scroll);
                    check_field("cell_value", want.cell_value, result_bus.cell_value);
                    results_checked++;
                end
            end
            // drop ready after a transaction or now and then
            if (sink_stall == 0 && (result_fired || $urandom_range(19) == 0))
                sink_stall = pick_idle(1);
            if (sink_stall > 0)
            begin
                sink_stall--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        item_bus.valid      = 1'b0;
        item_bus.kind       = '0;
        item_bus.char_code  = '0;
        item_bus.target_row = '0;
        item_bus.target_col = '0;
        item_bus.read_index = '0;
        result_bus.ready    = 1'b0;
        cycle_count = 0;
        errors = 0;
        queued_total = 0;
        commands_sent = 0;
        results_checked = 0;
        scroll_count = 0;
        attr_settings = 0;
        kind_count = '{default: 0};
        calm_left = '{default: 0};
        src_gap = 0;
        sink_stall = 0;
        for (int i = 0; i < CELLS; i++)
            screen_shadow[i] = RESET_CELL;
        shadow_row = 0;
        shadow_col = 0;
        shadow_attr = ATTR_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset contents, byte classes, cursor controls, edges
        push_read(0);
        push_read(CELLS - 1);
        push_read(MAX_INDEX);
        push_print(8'h41);
        push_print(CHAR_DEL);
        push_print(CHAR_BLANK);
        push_print(8'h80);
        push_print(8'hFF);
        push_print(8'h00);
        push_print(CHAR_BS);
        push_print(CHAR_TAB);
        push_move(5, 0);
        push_print(CHAR_BS);
        push_move(0, COLS - 2);
        push_print(CHAR_TAB);
        push_print(CHAR_CR);
        push_print(CHAR_LF);
        push_move(ROWS, 0);
        push_move(0, COLS);
        push_move(31, 127);
        push_move(LAST_ROW, COLS - 1);
        push_print(8'h5A);
        push_read(LAST_ROW * COLS - 1);
        push_move(LAST_ROW, 10);
        push_print(CHAR_LF);
        push_clear();
        push_read(CELLS - 1);
        wait_idle();

        // Random phases, each under its own attribute
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: program_attribute(8'hFF);
                1: program_attribute(8'h00);
                4: program_attribute(ATTR_RESET);
                default: program_attribute(ATTR_W'($urandom_range(255)));
            endcase
            if ($urandom_range(1))
                push_clear();
            fill_random(PHASE_ITEMS);
            wait_idle();
        end

        $display("summary: %0d commands (%0d print, %0d clear, %0d move, %0d read), %0d scrolls",
                 commands_sent, kind_count[KIND_PRINT], kind_count[KIND_CLEAR],
                 kind_count[KIND_MOVE], kind_count[KIND_READ], scroll_count);
        $display("summary: %0d results checked over %0d attribute settings",
                 results_checked, attr_settings);
        if (errors == 0 && awaited_views.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_item_if.sv
rtl/core/tcw_result_if.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer_top.sv
bench/text_console_writer_top_tb.sv
